// File: design/ccma_pkg.sv
`default_nettype none
package ccma_pkg;

	// Set size limit and derived widths
	localparam int MAX_PARTICLES = 16384;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int SUM_W = 40;
	localparam int ACC_W = 64;
	localparam int CFG_W = 24;
	localparam int REG_IDX_W = 3;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QFILL_W = $clog2(QDEPTH + 1);
	localparam int ROT_STEPS = 24;
	localparam int STEP_W = $clog2(ROT_STEPS);
	localparam int WK_W = 4;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CY = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CZ = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_QW = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_QX = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_QY = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_QZ = 3'd7;

	localparam logic signed [17:0] QUAT_W_RESET = 18'sd65536;

	// Rotation work register slots
	localparam logic [WK_W-1:0] W_V0 = 4'd0;
	localparam logic [WK_W-1:0] W_V1 = 4'd1;
	localparam logic [WK_W-1:0] W_V2 = 4'd2;
	localparam logic [WK_W-1:0] W_A0 = 4'd3;
	localparam logic [WK_W-1:0] W_A1 = 4'd4;
	localparam logic [WK_W-1:0] W_A2 = 4'd5;
	localparam logic [WK_W-1:0] W_B0 = 4'd6;
	localparam logic [WK_W-1:0] W_B1 = 4'd7;
	localparam logic [WK_W-1:0] W_B2 = 4'd8;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] ref_x;
		logic signed [23:0] ref_y;
		logic signed [23:0] ref_z;
		logic               last_particle;
	} item_t;

	typedef struct packed {
		logic signed [63:0] m00;
		logic signed [63:0] m01;
		logic signed [63:0] m02;
		logic signed [63:0] m10;
		logic signed [63:0] m11;
		logic signed [63:0] m12;
		logic signed [63:0] m20;
		logic signed [63:0] m21;
		logic signed [63:0] m22;
		logic signed [23:0] mean_x;
		logic signed [23:0] mean_y;
		logic signed [23:0] mean_z;
	} result_t;

	typedef struct packed {
		logic [1:0]         mode_flags;
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic signed [23:0] center_z;
		logic signed [17:0] quat_w;
		logic signed [17:0] quat_x;
		logic signed [17:0] quat_y;
		logic signed [17:0] quat_z;
	} cfg_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_FIN, ST_DIV, ST_CEN, ST_LDC, ST_ROT, ST_STC, ST_DONE
	} state_t;

	typedef enum logic [1:0] {OP_LD, OP_ADD, OP_SUB} rop_t;
	typedef enum logic [1:0] {Q_W, Q_X, Q_Y, Q_Z} qsel_t;

	typedef struct packed {
		logic [WK_W-1:0] src;
		qsel_t           qsel;
		logic            mul;
		rop_t            op;
		logic            wr;
		logic [WK_W-1:0] dst;
	} uop_t;

	// Rotation sequence for one column: a = v x q + w v, b = a x q, v += 2b
	function automatic uop_t rot_uop(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = '{W_V1, Q_Z, 1'b1, OP_LD,  1'b0, W_A0};
			5'd1:  u = '{W_V2, Q_Y, 1'b1, OP_SUB, 1'b0, W_A0};
			5'd2:  u = '{W_V0, Q_W, 1'b1, OP_ADD, 1'b1, W_A0};
			5'd3:  u = '{W_V2, Q_X, 1'b1, OP_LD,  1'b0, W_A1};
			5'd4:  u = '{W_V0, Q_Z, 1'b1, OP_SUB, 1'b0, W_A1};
			5'd5:  u = '{W_V1, Q_W, 1'b1, OP_ADD, 1'b1, W_A1};
			5'd6:  u = '{W_V0, Q_Y, 1'b1, OP_LD,  1'b0, W_A2};
			5'd7:  u = '{W_V1, Q_X, 1'b1, OP_SUB, 1'b0, W_A2};
			5'd8:  u = '{W_V2, Q_W, 1'b1, OP_ADD, 1'b1, W_A2};
			5'd9:  u = '{W_A1, Q_Z, 1'b1, OP_LD,  1'b0, W_B0};
			5'd10: u = '{W_A2, Q_Y, 1'b1, OP_SUB, 1'b1, W_B0};
			5'd11: u = '{W_A2, Q_X, 1'b1, OP_LD,  1'b0, W_B1};
			5'd12: u = '{W_A0, Q_Z, 1'b1, OP_SUB, 1'b1, W_B1};
			5'd13: u = '{W_A0, Q_Y, 1'b1, OP_LD,  1'b0, W_B2};
			5'd14: u = '{W_A1, Q_X, 1'b1, OP_SUB, 1'b1, W_B2};
			5'd15: u = '{W_V0, Q_W, 1'b0, OP_LD,  1'b0, W_V0};
			5'd16: u = '{W_B0, Q_W, 1'b0, OP_ADD, 1'b0, W_V0};
			5'd17: u = '{W_B0, Q_W, 1'b0, OP_ADD, 1'b1, W_V0};
			5'd18: u = '{W_V1, Q_W, 1'b0, OP_LD,  1'b0, W_V1};
			5'd19: u = '{W_B1, Q_W, 1'b0, OP_ADD, 1'b0, W_V1};
			5'd20: u = '{W_B1, Q_W, 1'b0, OP_ADD, 1'b1, W_V1};
			5'd21: u = '{W_V2, Q_W, 1'b0, OP_LD,  1'b0, W_V2};
			5'd22: u = '{W_B2, Q_W, 1'b0, OP_ADD, 1'b0, W_V2};
			5'd23: u = '{W_B2, Q_W, 1'b0, OP_ADD, 1'b1, W_V2};
			default: u = '{W_V0, Q_W, 1'b0, OP_LD, 1'b0, W_V0};
		endcase
		return u;
	endfunction

	function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_sat64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] add_sat40(input logic signed [SUM_W-1:0] a,
			input logic signed [23:0] b);
		logic signed [SUM_W:0] s;
		s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: design/ccma_front.sv
`default_nettype none
module ccma_front import ccma_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  item_t  item,
	input  logic   pop,
	output qhead_t head
);

	item_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wp_q;
	logic [QPTR_W-1:0]   rp_q;
	logic [QFILL_W-1:0]  fill_q;
	logic                push;

	// Accept a request while the queue has room
	assign busy = (fill_q == QFILL_W'(QDEPTH));
	assign push = start && !busy;
	assign head.valid = (fill_q != '0);
	assign head.item = mem_q[rp_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			fill_q <= fill_q + QFILL_W'(push) - QFILL_W'(pop);
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= item;
	end

endmodule
`default_nettype wire

// File: design/ccma_back.sv
`default_nettype none
module ccma_back import ccma_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  qhead_t  head,
	output logic    pop,
	output logic    idle,
	output logic    result_valid,
	output result_t result
);

	state_t state_q, state_d;

	logic [1:0]              ph_q;
	logic [1:0]              i_q;
	logic [1:0]              j_q;
	logic [STEP_W-1:0]       step_q;
	logic [5:0]              bit_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [ACC_W-1:0] cross_q [9];
	logic signed [SUM_W-1:0] psum_q [3];
	logic signed [SUM_W-1:0] rsum_q [3];
	logic                    valid_q;

	item_t                   item_q;
	logic signed [47:0]      prod_s1;
	logic signed [23:0]      center_q [3];
	logic                    dneg_q;
	logic [SUM_W-1:0]        dq_q;
	logic [CNT_W-1:0]        rem_q;
	logic signed [44:0]      plo_s1;
	logic signed [43:0]      phi_s1;
	logic signed [ACC_W-1:0] wk_q [9];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term_q;
	logic signed [50:0]      mlo_s1;
	logic signed [49:0]      mhi_s1;
	result_t                 result_q;

	logic signed [23:0]      p_sel, r_sel, c_sel;
	logic signed [SUM_W-1:0] psum_sel, rsum_sel;
	logic [SUM_W-1:0]        mag;
	logic [CNT_W:0]          dtry;
	logic                    dge;
	logic [CNT_W:0]          drem;
	logic [23:0]             qmag;
	logic signed [ACC_W-1:0] cprod;
	uop_t                    uop;
	logic signed [ACC_W-1:0] src_val;
	logic signed [17:0]      q_sel;
	logic signed [82:0]      full;
	logic signed [66:0]      shv;
	logic signed [ACC_W-1:0] mulq_val;
	logic signed [ACC_W-1:0] acc_new;
	logic                    last_k;

	assign idle = (state_q == ST_IDLE);
	assign result_valid = valid_q;
	assign result = result_q;
	assign last_k = (i_q == 2'd2) && (j_q == 2'd2);

	// Select operands
	always_comb begin
		case (i_q)
			2'd0: p_sel = item_q.pos_x;
			2'd1: p_sel = item_q.pos_y;
			default: p_sel = item_q.pos_z;
		endcase
		case (j_q)
			2'd0: r_sel = item_q.ref_x;
			2'd1: r_sel = item_q.ref_y;
			default: r_sel = item_q.ref_z;
		endcase
		c_sel = center_q[i_q];
		psum_sel = psum_q[i_q];
		rsum_sel = rsum_q[j_q];
	end

	// Divider step and centering product
	always_comb begin
		mag = psum_sel[SUM_W-1] ? SUM_W'(-psum_sel) : psum_sel;
		dtry = {rem_q, dq_q[SUM_W-1]};
		dge = (dtry >= {1'b0, cnt_q});
		drem = dge ? dtry - {1'b0, cnt_q} : dtry;
		qmag = dq_q[23:0];
		cprod = (64'(phi_s1) <<< 20) + 64'(plo_s1);
	end

	// Rotation datapath: floor(v * q / 2^16) clamped, then accumulate
	always_comb begin
		uop = rot_uop(step_q);
		src_val = wk_q[uop.src];
		case (uop.qsel)
			Q_W: q_sel = cfg.quat_w;
			Q_X: q_sel = cfg.quat_x;
			Q_Y: q_sel = cfg.quat_y;
			default: q_sel = cfg.quat_z;
		endcase
		full = (83'(mhi_s1) <<< 32) + 83'(mlo_s1);
		shv = full[82:16];
		if (shv[66:63] != {4{shv[63]}})
			mulq_val = shv[66] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			mulq_val = shv[63:0];
		case (uop.op)
			OP_LD: acc_new = term_q;
			OP_ADD: acc_new = add_sat64(acc_q, term_q);
			default: acc_new = sub_sat64(acc_q, term_q);
		endcase
	end

	// Next state and queue pop
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (cnt_q < CNT_W'(MAX_PARTICLES)) state_d = ST_ACC;
					else if (head.item.last_particle) state_d = ST_FIN;
				end
			end
			ST_ACC: begin
				if (ph_q == 2'd1 && last_k) state_d = item_q.last_particle ? ST_FIN : ST_IDLE;
			end
			ST_FIN: state_d = cfg.mode_flags[0] ? ST_CEN : ST_DIV;
			ST_DIV: begin
				if (ph_q == 2'd2 && i_q == 2'd2) state_d = ST_CEN;
			end
			ST_CEN: begin
				if (ph_q == 2'd2 && last_k) state_d = cfg.mode_flags[1] ? ST_LDC : ST_DONE;
			end
			ST_LDC: state_d = ST_ROT;
			ST_ROT: begin
				if (ph_q == 2'd3 && step_q == STEP_W'(ROT_STEPS - 1)) state_d = ST_STC;
			end
			ST_STC: state_d = (j_q == 2'd2) ? ST_DONE : ST_LDC;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequence counters and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= '0;
			i_q <= '0;
			j_q <= '0;
			step_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			valid_q <= 1'b0;
			for (int k = 0; k < 9; k++) cross_q[k] <= '0;
			for (int k = 0; k < 3; k++) begin
				psum_q[k] <= '0;
				rsum_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE, ST_FIN: begin
					ph_q <= '0;
					i_q <= '0;
					j_q <= '0;
				end
				ST_ACC: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						// Rotate the cross sums past the adder
						ph_q <= 2'd0;
						for (int k = 0; k < 8; k++) cross_q[k] <= cross_q[k+1];
						cross_q[8] <= add_sat64(cross_q[0], 64'(prod_s1));
						if (j_q == 2'd2) begin
							j_q <= '0;
							if (i_q == 2'd2) begin
								i_q <= '0;
								cnt_q <= cnt_q + 1'b1;
								psum_q[0] <= add_sat40(psum_q[0], item_q.pos_x);
								psum_q[1] <= add_sat40(psum_q[1], item_q.pos_y);
								psum_q[2] <= add_sat40(psum_q[2], item_q.pos_z);
								rsum_q[0] <= add_sat40(rsum_q[0], item_q.ref_x);
								rsum_q[1] <= add_sat40(rsum_q[1], item_q.ref_y);
								rsum_q[2] <= add_sat40(rsum_q[2], item_q.ref_z);
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					case (ph_q)
						2'd0: begin
							ph_q <= 2'd1;
							bit_q <= '0;
						end
						2'd1: begin
							bit_q <= bit_q + 1'b1;
							if (bit_q == 6'(SUM_W - 1)) ph_q <= 2'd2;
						end
						default: begin
							ph_q <= 2'd0;
							j_q <= '0;
							i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
						end
					endcase
				end
				ST_CEN: begin
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 1'b1;
					end else begin
						ph_q <= 2'd0;
						for (int k = 0; k < 8; k++) cross_q[k] <= cross_q[k+1];
						cross_q[8] <= sub_sat64(cross_q[0], cprod);
						if (j_q == 2'd2) begin
							j_q <= '0;
							i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_LDC: begin
					ph_q <= '0;
					step_q <= '0;
				end
				ST_ROT: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd3) step_q <= step_q + 1'b1;
				end
				ST_STC: begin
					// Store the rotated column and bring the next one to the front
					for (int r = 0; r < 3; r++) begin
						cross_q[3*r]   <= cross_q[3*r+1];
						cross_q[3*r+1] <= cross_q[3*r+2];
						cross_q[3*r+2] <= wk_q[r];
					end
					j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 1'b1;
				end
				ST_DONE: begin
					valid_q <= 1'b1;
					cnt_q <= '0;
					for (int k = 0; k < 9; k++) cross_q[k] <= '0;
					for (int k = 0; k < 3; k++) begin
						psum_q[k] <= '0;
						rsum_q[k] <= '0;
					end
				end
				default: ph_q <= '0;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) item_q <= head.item;
			end
			ST_ACC: begin
				if (ph_q == 2'd0) prod_s1 <= p_sel * r_sel;
			end
			ST_FIN: begin
				if (cfg.mode_flags[0]) begin
					center_q[0] <= cfg.center_x;
					center_q[1] <= cfg.center_y;
					center_q[2] <= cfg.center_z;
				end
			end
			ST_DIV: begin
				case (ph_q)
					2'd0: begin
						dneg_q <= psum_sel[SUM_W-1];
						dq_q <= mag;
						rem_q <= '0;
					end
					2'd1: begin
						rem_q <= drem[CNT_W-1:0];
						dq_q <= {dq_q[SUM_W-2:0], dge};
					end
					default: begin
						if (cnt_q == '0) center_q[i_q] <= '0;
						else center_q[i_q] <= dneg_q ? 24'(-qmag) : qmag;
					end
				endcase
			end
			ST_CEN: begin
				if (ph_q == 2'd0) plo_s1 <= c_sel * $signed({1'b0, rsum_sel[19:0]});
				if (ph_q == 2'd1) phi_s1 <= c_sel * $signed(rsum_sel[SUM_W-1:20]);
			end
			ST_LDC: begin
				wk_q[0] <= cross_q[0];
				wk_q[1] <= cross_q[3];
				wk_q[2] <= cross_q[6];
			end
			ST_ROT: begin
				case (ph_q)
					2'd0: mlo_s1 <= $signed({1'b0, src_val[31:0]}) * q_sel;
					2'd1: mhi_s1 <= $signed(src_val[63:32]) * q_sel;
					2'd2: term_q <= uop.mul ? mulq_val : src_val;
					default: begin
						acc_q <= acc_new;
						if (uop.wr) wk_q[uop.dst] <= acc_new;
					end
				endcase
			end
			ST_DONE: begin
				result_q.m00 <= cross_q[0];
				result_q.m01 <= cross_q[1];
				result_q.m02 <= cross_q[2];
				result_q.m10 <= cross_q[3];
				result_q.m11 <= cross_q[4];
				result_q.m12 <= cross_q[5];
				result_q.m20 <= cross_q[6];
				result_q.m21 <= cross_q[7];
				result_q.m22 <= cross_q[8];
				result_q.mean_x <= center_q[0];
				result_q.mean_y <= center_q[1];
				result_q.mean_z <= center_q[2];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: design/centered_correlation_matrix_accumulator_unit.sv
`default_nettype none
// Centered correlation matrix accumulator.
// Requests: one particle per request (position, reference, last flag) on item,
// taken at a clock edge with start high and busy low. A two-entry queue sits
// in front of the sequencer, so busy rises only when both entries are held.
// In the sequencer each particle is taken from the queue; up to 16384 per
// set then go through nine multiply-accumulates on one 24x24 multiplier,
// while later ones only end the set by their last flag.
// On the last particle the sequencer then solves the set: it picks the
// center, takes the mean per axis by a shared restoring divider (skipped
// with the fixed center), centers the matrix, with rotation on turns each
// column through one 33x18 multiplier, and latches the matrix. The result
// appears the cycle after, for exactly one cycle, on result with
// result_valid high; the receiver cannot stall it.
// Configuration: wr_en, wr_index, wr_data write one register per cycle; write
// only while the block is idle.
// Reset (arst_n low) clears all sums, the count, the queue and the registers
// (quat_w to 1.0).
module centered_correlation_matrix_accumulator_unit import ccma_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	cfg_t   cfg_q;
	qhead_t head;
	logic   pop;
	logic   idle;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{2'b00, 24'sd0, 24'sd0, 24'sd0, QUAT_W_RESET, 18'sd0, 18'sd0, 18'sd0};
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE: cfg_q.mode_flags <= wr_data[1:0];
				REG_CX: cfg_q.center_x <= wr_data;
				REG_CY: cfg_q.center_y <= wr_data;
				REG_CZ: cfg_q.center_z <= wr_data;
				REG_QW: cfg_q.quat_w <= wr_data[17:0];
				REG_QX: cfg_q.quat_x <= wr_data[17:0];
				REG_QY: cfg_q.quat_y <= wr_data[17:0];
				REG_QZ: cfg_q.quat_z <= wr_data[17:0];
				default: ;
			endcase
		end
	end

	ccma_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.pop    (pop),
		.head   (head)
	);

	ccma_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.pop          (pop),
		.idle         (idle),
		.result_valid (result_valid),
		.result       (result)
	);

	// Strobe lasts one cycle
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// A result is shown only after the sequencer finished the set
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (idle && !$past(idle)))
		else $error("result without a completed solve");

endmodule
`default_nettype wire

// File: tb/sv/centered_correlation_matrix_accumulator_unit_checker.sv
`timescale 1ns / 1ps
module centered_correlation_matrix_accumulator_unit_checker import ccma_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  item_t                item,
	input  logic                 result_valid,
	input  result_t              result,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output int                   errors,
	output int                   pending
);

	// Register copies
	logic [1:0]         mode;
	logic signed [23:0] fixed_center [3];
	logic signed [17:0] q_w, q_x, q_y, q_z;

	// Running set sums
	longint             cross_acc [9];
	longint             pos_acc [3];
	longint             ref_acc [3];
	int                 set_count;

	result_t            matrix_queue [$];

	localparam longint POS40 = 64'sd549755813887;
	localparam longint NEG40 = -64'sd549755813888;

	function automatic longint sat_sum(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic longint sat_diff(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	// v * q / 2^16, floored, clamped to 64 bits
	function automatic longint scale_q(input longint v, input logic signed [17:0] q);
		logic signed [81:0] pr;
		logic signed [65:0] sh;
		pr = 82'(v) * 82'(q);
		sh = 66'(pr >>> 16);
		if (sh > 66'sh0_7FFF_FFFF_FFFF_FFFF) return {1'b0, {63{1'b1}}};
		if (sh < -66'sh0_8000_0000_0000_0000) return {1'b1, 63'd0};
		return sh[63:0];
	endfunction

	// Rotate one column: a = v x q + w v, b = a x q, v += 2b
	function automatic void turn_column(inout longint v0, inout longint v1, inout longint v2);
		longint a0, a1, a2, b0, b1, b2;
		a0 = sat_sum(sat_diff(scale_q(v1, q_z), scale_q(v2, q_y)), scale_q(v0, q_w));
		a1 = sat_sum(sat_diff(scale_q(v2, q_x), scale_q(v0, q_z)), scale_q(v1, q_w));
		a2 = sat_sum(sat_diff(scale_q(v0, q_y), scale_q(v1, q_x)), scale_q(v2, q_w));
		b0 = sat_diff(scale_q(a1, q_z), scale_q(a2, q_y));
		b1 = sat_diff(scale_q(a2, q_x), scale_q(a0, q_z));
		b2 = sat_diff(scale_q(a0, q_y), scale_q(a1, q_x));
		v0 = sat_sum(sat_sum(v0, b0), b0);
		v1 = sat_sum(sat_sum(v1, b1), b1);
		v2 = sat_sum(sat_sum(v2, b2), b2);
	endfunction

	function automatic longint clamp40(input longint s);
		if (s > POS40) return POS40;
		if (s < NEG40) return NEG40;
		return s;
	endfunction

	function automatic void clear_set();
		for (int k = 0; k < 9; k++) cross_acc[k] = 0;
		for (int k = 0; k < 3; k++) begin
			pos_acc[k] = 0;
			ref_acc[k] = 0;
		end
		set_count = 0;
	endfunction

	// Accumulate one particle, and on the last one queue the centered matrix
	function automatic void absorb_particle(input item_t it);
		longint p [3], r [3], c [3], m [9];
		result_t exp_res;
		p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
		r[0] = it.ref_x; r[1] = it.ref_y; r[2] = it.ref_z;
		if (set_count < MAX_PARTICLES) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					cross_acc[3*i+j] = sat_sum(cross_acc[3*i+j], p[i] * r[j]);
			for (int i = 0; i < 3; i++) begin
				pos_acc[i] = clamp40(pos_acc[i] + p[i]);
				ref_acc[i] = clamp40(ref_acc[i] + r[i]);
			end
			set_count++;
		end
		if (!it.last_particle) return;
		for (int i = 0; i < 3; i++) begin
			if (mode[0]) c[i] = fixed_center[i];
			else if (set_count == 0) c[i] = 0;
			else c[i] = pos_acc[i] / longint'(set_count);
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[3*i+j] = sat_diff(cross_acc[3*i+j], c[i] * ref_acc[j]);
		if (mode[1])
			for (int j = 0; j < 3; j++)
				turn_column(m[j], m[3+j], m[6+j]);
		exp_res = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
			c[0][23:0], c[1][23:0], c[2][23:0]};
		matrix_queue.push_back(exp_res);
		clear_set();
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	// Watch config writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			mode = '0;
			for (int k = 0; k < 3; k++) fixed_center[k] = '0;
			q_w = QUAT_W_RESET;
			q_x = '0; q_y = '0; q_z = '0;
			clear_set();
			matrix_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MODE: mode = wr_data[1:0];
					REG_CX:   fixed_center[0] = wr_data;
					REG_CY:   fixed_center[1] = wr_data;
					REG_CZ:   fixed_center[2] = wr_data;
					REG_QW:   q_w = wr_data[17:0];
					REG_QX:   q_x = wr_data[17:0];
					REG_QY:   q_y = wr_data[17:0];
					REG_QZ:   q_z = wr_data[17:0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (matrix_queue.size() == 0) begin
					$error("result with no request pending");
					errors++;
				end else begin
					want = matrix_queue.pop_front();
					check_field("m00", want.m00, result.m00);
					check_field("m01", want.m01, result.m01);
					check_field("m02", want.m02, result.m02);
					check_field("m10", want.m10, result.m10);
					check_field("m11", want.m11, result.m11);
					check_field("m12", want.m12, result.m12);
					check_field("m20", want.m20, result.m20);
					check_field("m21", want.m21, result.m21);
					check_field("m22", want.m22, result.m22);
					check_field("mean_x", 64'(want.mean_x), 64'(result.mean_x));
					check_field("mean_y", 64'(want.mean_y), 64'(result.mean_y));
					check_field("mean_z", 64'(want.mean_z), 64'(result.mean_z));
				end
			end
			if (start && !busy) absorb_particle(item);
			pending = matrix_queue.size();
		end
	end

endmodule

// File: tb/sv/centered_correlation_matrix_accumulator_unit_test.sv
`timescale 1ns / 1ps
module centered_correlation_matrix_accumulator_unit_test;
	import ccma_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	item_t                item = '0;
	logic                 result_valid;
	result_t              result;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = REG_MODE;
	logic [CFG_W-1:0]     wr_data = '0;
	int                   errors;
	int                   pending;

	localparam logic [23:0] C_MAX = 24'h7FFFFF;
	localparam logic [23:0] C_MIN = 24'h800000;

	always #6 clk = ~clk;

	centered_correlation_matrix_accumulator_unit dut (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.wr_en, .wr_index, .wr_data
	);

	centered_correlation_matrix_accumulator_unit_checker chk (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.wr_en, .wr_index, .wr_data, .errors, .pending
	);

	// Hold the request until it is taken; start stays high for the next one
	task automatic send_particle(input item_t it);
		start <= 1'b1;
		item <= it;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Drive one register write; the caller drops wr_en after the last one
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(negedge clk);
	endtask

	// Wait for every matrix, then let the sequencer settle
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_all(input logic [1:0] md, input logic [23:0] cx, input logic [23:0] cy,
			input logic [23:0] cz, input logic [23:0] qw, input logic [23:0] qx,
			input logic [23:0] qy, input logic [23:0] qz);
		write_reg(REG_MODE, {22'($urandom_range(0, 4194303)), md});
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
		write_reg(REG_CZ, cz);
		write_reg(REG_QW, qw);
		write_reg(REG_QX, qx);
		write_reg(REG_QY, qy);
		write_reg(REG_QZ, qz);
		wr_en <= 1'b0;
	endtask

	function automatic logic [23:0] rand_coord(input int span);
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2: return 24'($urandom_range(0, span)) - 24'(span / 2);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rand_quat();
		case ($urandom_range(0, 5))
			0: return 24'h01FFFF;
			1: return 24'hFE0000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic item_t make_particle(input logic last, input int span);
		return '{rand_coord(span), rand_coord(span), rand_coord(span),
			rand_coord(span), rand_coord(span), rand_coord(span), last};
	endfunction

	// Timeout
	initial begin
		#40ms;
		$display("** centered_correlation_matrix_accumulator_unit: FAILED **");
		$finish;
	end

	initial begin
		int sent, set_len, burst, span;
		item_t it;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes with reset registers (mean center, no rotation)
		send_particle('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1});
		send_particle('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1});
		send_particle('{C_MAX, C_MIN, 24'd0, C_MIN, C_MAX, 24'd1, 1'b0});
		send_particle('{C_MIN, C_MAX, 24'hFFFFFF, C_MAX, C_MIN, 24'd4096, 1'b0});
		send_particle('{24'hFFFFFF, 24'd3, 24'hFFFFFD, 24'd7, 24'hFFFFF9, 24'd0, 1'b1});
		send_particle('{24'hFFFFFF, 24'd0, 24'd1, 24'd1, 24'd1, 24'd1, 1'b0});
		send_particle('{24'hFFFFFE, 24'd0, 24'd1, 24'd1, 24'd1, 24'd1, 1'b1});
		drain();
		// Directed: fixed center and rotation at extreme registers
		write_all(2'b11, C_MAX, C_MIN, 24'd0, 24'h01FFFF, 24'hFE0000, 24'h01FFFF, 24'hFE0000);
		send_particle('{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1});
		send_particle('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0});
		send_particle('{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1});
		drain();
		write_all(2'b10, C_MIN, C_MAX, C_MIN, 24'hFE0000, 24'h01FFFF, 24'hFE0000, 24'h01FFFF);
		send_particle('{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1'b1});
		send_particle('{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1});
		drain();
		write_all(2'b01, 24'd4096, 24'hFFF000, 24'd1, 24'd65536, 24'd0, 24'd0, 24'd0);
		send_particle('{C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1});
		drain();

		// Random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			write_all(2'(ph), rand_coord(65535), rand_coord(65535), rand_coord(65535),
				rand_quat(), rand_quat(), rand_quat(), rand_quat());
			span = (ph % 2) ? 1 << 24 : 65535;
			sent = 0;
			set_len = 0;
			burst = $urandom_range(1, 20);
			while (sent < 250) begin
				if (set_len == 0)
					set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
				set_len--;
				// Mostly well-formed sets; a stray last flag now and then
				it = make_particle(set_len == 0 || $urandom_range(0, 49) == 0, span);
				if (it.last_particle) set_len = 0;
				send_particle(it);
				sent++;
				if (--burst == 0) begin
					burst = $urandom_range(1, 20);
					if (ph != 3) pause_sender($urandom_range(0, 6));
				end
			end
			// End every phase on a last particle so the block is idle
			send_particle(make_particle(1'b1, span));
			drain();
		end

		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("** centered_correlation_matrix_accumulator_unit: PASSED **");
		else
			$display("** centered_correlation_matrix_accumulator_unit: FAILED **");
		$finish;
	end

endmodule
